FILE: sv/rppc_pkg.sv
`default_nettype none
package rppc_pkg;

	// Fixed field widths
	localparam int ENC_BITS   = 14;
	localparam int POS_W      = ENC_BITS + 1;
	localparam int INTEG_W    = 18;
	localparam int DERIV_W    = ENC_BITS + 2;
	localparam int RATE_W     = 12;
	localparam int PERIOD_W   = 20;
	localparam int STEPS_W    = 32;
	localparam int MUL_A_W    = 17;
	localparam int MUL_B_W    = 19;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int ACC_W      = 40;
	localparam int DIV_DVD_W  = 20;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 104;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int AVG_DEPTH_DEFAULT = 4;

	localparam logic [PERIOD_W-1:0] ONE_MILLION = 20'd1000000;

	// Op codes on s_tuser
	typedef enum logic [2:0] {
		OP_SAMPLE = 3'd0,
		OP_START  = 3'd1,
		OP_STOP   = 3'd2,
		OP_ZERO   = 3'd3,
		OP_TICK   = 3'd4
	} op_t;

	// Run modes
	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_MOVING = 2'd1,
		MODE_SETTLE = 2'd2,
		MODE_DONE   = 2'd3
	} mode_t;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_MAX   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_MIN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE     = 3'd7;

	// PID term selector for the shared multiplier
	typedef enum logic [1:0] {
		MUL_P = 2'd0,
		MUL_I = 2'd1,
		MUL_D = 2'd2
	} mul_sel_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_SUM,
		S_AVG,
		S_DECIDE,
		S_MUL_P,
		S_MUL_I,
		S_MUL_D,
		S_MUL_ACC,
		S_CLAMP,
		S_DIVP_GO,
		S_DIVP_WAIT,
		S_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic     accept;
		logic     sum_en;
		logic     div_start;
		logic     avg_load;
		logic     decide;
		mul_sel_t mul_sel;
		logic     mul_en;
		logic     acc_add;
		logic     clamp;
		logic     per_load;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic is_sample;
		logic sum_last;
		logic div_done;
		logic need_pid;
	} sts_t;

endpackage
`default_nettype wire

FILE: sv/rppc_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle
module rppc_divider #(
	parameter int DVD_W = 20,
	parameter int DVS_W = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic      [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   diff;
	logic             ge;

	// Trial subtract
	always_comb begin
		rem_sh = {rem_q, quo_q[DVD_W-1]};
		diff   = rem_sh - {1'b0, dvs_q};
		ge     = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
			cnt_q  <= CNT_W'(DVD_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: sv/rppc_datapath.sv
`default_nettype none
module rppc_datapath #(
	parameter int AVG_DEPTH = rppc_pkg::AVG_DEPTH_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [rppc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rppc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic [2:0]                          in_op,
	input  wire logic [rppc_pkg::ENC_BITS-1:0]       in_raw,
	input  wire logic [rppc_pkg::ENC_BITS-1:0]       in_tgt,
	input  wire rppc_pkg::cmd_t                      cmd,
	output rppc_pkg::sts_t                           sts,
	output logic      [rppc_pkg::M_TDATA_W-1:0]      res_data
);

	localparam int EB    = rppc_pkg::ENC_BITS;
	localparam int IDX_W = $clog2(AVG_DEPTH);
	localparam int SUM_W = EB + IDX_W;
	localparam int DW    = rppc_pkg::DIV_DVD_W;
	localparam int RW    = rppc_pkg::RATE_W;
	localparam int AW    = rppc_pkg::ACC_W;
	localparam int D_W   = EB + 3;
	localparam logic signed [D_W-1:0] HALF = D_W'(1 << (EB - 1));
	localparam logic signed [D_W-1:0] FULL = D_W'(1 << EB);
	// Average by reciprocal multiplication, exact over the whole sum range
	localparam int RCP_K = SUM_W + IDX_W + 1;
	localparam logic [RCP_K-1:0] RCP_M =
		RCP_K'(((64'd1 << RCP_K) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

	// Configuration registers
	logic [15:0]   gain_prop_q, gain_integ_q, gain_deriv_q, integ_lim_q, settle_ticks_q;
	logic [RW-1:0] rate_max_q, rate_min_q;
	logic [9:0]    tol_q;

	// Controller state
	logic [EB-1:0]    hist_q [AVG_DEPTH];
	logic [IDX_W-1:0] slot_q, idx_q;
	logic [SUM_W-1:0] sum_q;
	logic [EB-1:0]    avg_q, zero_q, target_q;
	logic signed [rppc_pkg::INTEG_W-1:0] integ_q;
	logic signed [rppc_pkg::POS_W-1:0]   last_err_q;
	logic signed [rppc_pkg::DERIV_W-1:0] deriv_q;
	rppc_pkg::mode_t  mode_q;
	logic [15:0]      settle_cnt_q;
	logic [rppc_pkg::STEPS_W-1:0]  steps_q;
	logic             enable_q;
	logic signed [rppc_pkg::PROD_W-1:0] prod_s1;
	logic signed [AW-1:0]          acc_q;
	logic             cw_q, pulse_q;
	logic [RW-1:0]    rate_q;
	logic [rppc_pkg::PERIOD_W-1:0] period_q;
	logic [rppc_pkg::M_TDATA_W-1:0] res_q;

	// Combinational terms
	logic [SUM_W+RCP_K-1:0]           avg_prod;
	logic signed [rppc_pkg::POS_W-1:0] pos;
	logic signed [D_W-1:0]            dif, dif_w;
	logic signed [rppc_pkg::POS_W-1:0] err;
	logic [EB-1:0]                    err_abs;
	logic                             err_small;
	logic signed [rppc_pkg::INTEG_W:0] integ_sum, lim_s, integ_new;
	logic signed [rppc_pkg::MUL_A_W-1:0] mul_a;
	logic signed [rppc_pkg::MUL_B_W-1:0] mul_b;
	logic signed [AW-1:0]             omax, acc_c, mag, rmin_sh;
	logic                             dead;
	logic [RW-1:0]                    rate_raw, rmin, rate_fin;
	logic                             div_done;
	logic [DW-1:0]                    div_quo;

	// History sum divided by the depth
	assign avg_prod = sum_q * RCP_M;

	// Position and wrapped error from the current state
	always_comb begin
		pos = $signed({1'b0, avg_q}) - $signed({1'b0, zero_q});
		dif = $signed({3'b000, target_q}) - $signed({{2{pos[rppc_pkg::POS_W-1]}}, pos});
		if (dif > HALF + FULL) begin
			dif_w = dif - FULL - FULL;
		end else if (dif > HALF) begin
			dif_w = dif - FULL;
		end else if (dif < -HALF) begin
			dif_w = dif + FULL;
		end else begin
			dif_w = dif;
		end
		err       = dif_w[rppc_pkg::POS_W-1:0];
		err_abs   = err[rppc_pkg::POS_W-1] ? EB'(-err) : EB'(err);
		err_small = {{(EB-10){1'b0}}, tol_q} > err_abs;
	end

	// Integral update with symmetric clamp
	always_comb begin
		integ_sum = {integ_q[rppc_pkg::INTEG_W-1], integ_q}
			+ {{(rppc_pkg::INTEG_W+1-rppc_pkg::POS_W){err[rppc_pkg::POS_W-1]}}, err};
		lim_s = $signed({3'b000, integ_lim_q});
		if (integ_sum > lim_s) begin
			integ_new = lim_s;
		end else if (integ_sum < -lim_s) begin
			integ_new = -lim_s;
		end else begin
			integ_new = integ_sum;
		end
	end

	// Shared multiplier operands
	always_comb begin
		unique case (cmd.mul_sel)
			rppc_pkg::MUL_I: begin
				mul_a = $signed({1'b0, gain_integ_q});
				mul_b = {integ_q[rppc_pkg::INTEG_W-1], integ_q};
			end
			rppc_pkg::MUL_D: begin
				mul_a = $signed({1'b0, gain_deriv_q});
				mul_b = {{(rppc_pkg::MUL_B_W-rppc_pkg::DERIV_W){deriv_q[rppc_pkg::DERIV_W-1]}},
					deriv_q};
			end
			default: begin
				mul_a = $signed({1'b0, gain_prop_q});
				mul_b = {{(rppc_pkg::MUL_B_W-rppc_pkg::POS_W){err[rppc_pkg::POS_W-1]}}, err};
			end
		endcase
	end

	// Output clamp, deadband and rate floor
	always_comb begin
		omax    = $signed({12'b0, rate_max_q, 16'b0});
		rmin_sh = $signed({12'b0, rate_min_q, 16'b0});
		if (acc_q > omax) begin
			acc_c = omax;
		end else if (acc_q < -omax) begin
			acc_c = -omax;
		end else begin
			acc_c = acc_q;
		end
		mag      = (acc_c < 0) ? -acc_c : acc_c;
		dead     = (mag < rmin_sh) && err_small;
		rate_raw = dead ? '0 : mag[16 +: RW];
		rmin     = (rate_min_q == '0) ? RW'(1) : rate_min_q;
		rate_fin = (rate_raw < rmin) ? rmin : rate_raw;
	end

	// Pulse period divider
	rppc_divider #(
		.DVD_W (DW),
		.DVS_W (RW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rppc_pkg::ONE_MILLION),
		.divisor  (rate_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q    <= 16'd3600;
			gain_integ_q   <= 16'd72;
			gain_deriv_q   <= 16'd1440;
			integ_lim_q    <= 16'd45511;
			rate_max_q     <= 12'd500;
			rate_min_q     <= 12'd10;
			tol_q          <= 10'd5;
			settle_ticks_q <= 16'd200;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rppc_pkg::REG_GAIN_PROP:  gain_prop_q    <= cfg_data;
				rppc_pkg::REG_GAIN_INTEG: gain_integ_q   <= cfg_data;
				rppc_pkg::REG_GAIN_DERIV: gain_deriv_q   <= cfg_data;
				rppc_pkg::REG_INTEG_LIM:  integ_lim_q    <= cfg_data;
				rppc_pkg::REG_RATE_MAX:   rate_max_q     <= cfg_data[RW-1:0];
				rppc_pkg::REG_RATE_MIN:   rate_min_q     <= cfg_data[RW-1:0];
				rppc_pkg::REG_TOLERANCE:  tol_q          <= cfg_data[9:0];
				default:                  settle_ticks_q <= cfg_data;
			endcase
		end
	end

	// Item processing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AVG_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			slot_q       <= '0;
			idx_q        <= '0;
			sum_q        <= '0;
			avg_q        <= '0;
			zero_q       <= '0;
			target_q     <= '0;
			integ_q      <= '0;
			last_err_q   <= '0;
			deriv_q      <= '0;
			mode_q       <= rppc_pkg::MODE_IDLE;
			settle_cnt_q <= '0;
			steps_q      <= '0;
			enable_q     <= 1'b1;
			prod_s1      <= '0;
			acc_q        <= '0;
			cw_q         <= 1'b0;
			pulse_q      <= 1'b0;
			rate_q       <= '0;
			period_q     <= '0;
		end else begin
			if (cmd.accept) begin
				cw_q     <= 1'b0;
				pulse_q  <= 1'b0;
				rate_q   <= '0;
				period_q <= '0;
				unique case (in_op)
					rppc_pkg::OP_SAMPLE: begin
						hist_q[slot_q] <= in_raw;
						slot_q <= (slot_q == IDX_W'(AVG_DEPTH - 1)) ? '0 : slot_q + IDX_W'(1);
						sum_q  <= '0;
						idx_q  <= '0;
					end
					rppc_pkg::OP_START: begin
						target_q   <= in_tgt;
						mode_q     <= rppc_pkg::MODE_MOVING;
						integ_q    <= '0;
						last_err_q <= '0;
						steps_q    <= '0;
						enable_q   <= 1'b1;
					end
					rppc_pkg::OP_STOP: begin
						mode_q   <= rppc_pkg::MODE_IDLE;
						enable_q <= 1'b0;
					end
					rppc_pkg::OP_ZERO: begin
						zero_q <= in_raw;
					end
					rppc_pkg::OP_TICK: begin
						if (mode_q == rppc_pkg::MODE_SETTLE && settle_cnt_q != 16'hFFFF) begin
							settle_cnt_q <= settle_cnt_q + 16'd1;
						end
					end
					default: begin
					end
				endcase
			end
			// History sum, one entry a cycle
			if (cmd.sum_en) begin
				sum_q <= sum_q + SUM_W'(hist_q[idx_q]);
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.avg_load) begin
				avg_q <= avg_prod[RCP_K +: EB];
			end
			// Mode transitions on a sample
			if (cmd.decide) begin
				acc_q <= '0;
				priority case (mode_q)
					rppc_pkg::MODE_MOVING: begin
						if (err_small) begin
							mode_q       <= rppc_pkg::MODE_SETTLE;
							settle_cnt_q <= '0;
						end else begin
							integ_q    <= integ_new[rppc_pkg::INTEG_W-1:0];
							deriv_q    <= {err[rppc_pkg::POS_W-1], err}
								- {last_err_q[rppc_pkg::POS_W-1], last_err_q};
							last_err_q <= err;
						end
					end
					rppc_pkg::MODE_SETTLE: begin
						if (settle_cnt_q >= settle_ticks_q) begin
							if (err_small) begin
								mode_q <= rppc_pkg::MODE_DONE;
							end else begin
								mode_q  <= rppc_pkg::MODE_MOVING;
								integ_q <= '0;
							end
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.mul_en) begin
				prod_s1 <= mul_a * mul_b;
			end
			if (cmd.acc_add) begin
				acc_q <= acc_q + AW'(prod_s1);
			end
			if (cmd.clamp) begin
				rate_q <= rate_fin;
				cw_q   <= !dead && (acc_c > 0);
			end
			if (cmd.per_load) begin
				period_q <= div_quo;
				pulse_q  <= 1'b1;
				steps_q  <= steps_q + 32'd1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q <= {4'b0000, (mode_q == rppc_pkg::MODE_DONE), err, pos, steps_q, period_q,
				rate_q, pulse_q, cw_q, enable_q, mode_q};
		end
	end

	assign res_data      = res_q;
	assign sts.is_sample = (in_op == rppc_pkg::OP_SAMPLE);
	assign sts.sum_last  = (idx_q == IDX_W'(AVG_DEPTH - 1));
	assign sts.div_done  = div_done;
	assign sts.need_pid  = (mode_q == rppc_pkg::MODE_MOVING) && !err_small;

endmodule
`default_nettype wire

FILE: sv/rppc_ctrl.sv
`default_nettype none
module rppc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	input  wire rppc_pkg::sts_t sts,
	output rppc_pkg::cmd_t      cmd
);

	rppc_pkg::ctrl_state_t state_q, state_d;
	logic                  m_tvalid_q;
	logic                  out_free;

	assign out_free = !m_tvalid_q || m_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rppc_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = sts.is_sample ? rppc_pkg::S_SUM : rppc_pkg::S_OUT;
				end
			end
			rppc_pkg::S_SUM: begin
				if (sts.sum_last) begin
					state_d = rppc_pkg::S_AVG;
				end
			end
			rppc_pkg::S_AVG:     state_d = rppc_pkg::S_DECIDE;
			rppc_pkg::S_DECIDE: begin
				state_d = sts.need_pid ? rppc_pkg::S_MUL_P : rppc_pkg::S_OUT;
			end
			rppc_pkg::S_MUL_P:   state_d = rppc_pkg::S_MUL_I;
			rppc_pkg::S_MUL_I:   state_d = rppc_pkg::S_MUL_D;
			rppc_pkg::S_MUL_D:   state_d = rppc_pkg::S_MUL_ACC;
			rppc_pkg::S_MUL_ACC: state_d = rppc_pkg::S_CLAMP;
			rppc_pkg::S_CLAMP:   state_d = rppc_pkg::S_DIVP_GO;
			rppc_pkg::S_DIVP_GO: state_d = rppc_pkg::S_DIVP_WAIT;
			rppc_pkg::S_DIVP_WAIT: begin
				if (sts.div_done) begin
					state_d = rppc_pkg::S_OUT;
				end
			end
			rppc_pkg::S_OUT: begin
				if (out_free) begin
					state_d = rppc_pkg::S_IDLE;
				end
			end
			default: state_d = rppc_pkg::S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd         = '0;
		cmd.mul_sel = rppc_pkg::MUL_P;
		s_tready    = 1'b0;
		unique case (state_q)
			rppc_pkg::S_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			rppc_pkg::S_SUM:    cmd.sum_en = 1'b1;
			rppc_pkg::S_AVG:    cmd.avg_load = 1'b1;
			rppc_pkg::S_DECIDE: cmd.decide = 1'b1;
			rppc_pkg::S_MUL_P: begin
				cmd.mul_en = 1'b1;
			end
			rppc_pkg::S_MUL_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rppc_pkg::MUL_I;
				cmd.acc_add = 1'b1;
			end
			rppc_pkg::S_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rppc_pkg::MUL_D;
				cmd.acc_add = 1'b1;
			end
			rppc_pkg::S_MUL_ACC:   cmd.acc_add = 1'b1;
			rppc_pkg::S_CLAMP:     cmd.clamp = 1'b1;
			rppc_pkg::S_DIVP_GO:   cmd.div_start = 1'b1;
			rppc_pkg::S_DIVP_WAIT: cmd.per_load = sts.div_done;
			rppc_pkg::S_OUT:       cmd.out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rppc_pkg::S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

	// The result register is never overwritten while it holds an untaken result
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result overwritten");

	// An accepted transaction always leaves the idle state
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != rppc_pkg::S_IDLE))
		else $error("accept did not start work");

	// The divider never reports done right after its start
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("divider done too early");

endmodule
`default_nettype wire

FILE: sv/rotary_position_pid_controller.sv
`default_nettype none
// Channel  Signals                          Transaction
// s        s_tvalid s_tready s_tdata s_tuser  one command item
// m        m_tvalid m_tready m_tdata          one status result per item
// cfg      cfg_valid cfg_ready cfg_index cfg_data  one register write
//
// Stop, start, set zero, tick and unused codes go from acceptance straight to
// the output state, which loads the result register; s_tready then returns.
// A sample runs the history sum, one entry per cycle, then the average and the
// mode decision; for a step it also runs the P, I and D products, the
// accumulate, the clamp and the pulse period divider before the output state.
// arst_n clears all but m_tdata to power-up values with the motor enabled.
// The next item is taken while a result waits; a stalled m side holds the
// sequencer before the result register only.
module rotary_position_pid_controller #(
	parameter int AVG_DEPTH = rppc_pkg::AVG_DEPTH_DEFAULT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// encoder_raw[13:0], target_position[27:14]
	input  wire logic [rppc_pkg::S_TDATA_W-1:0]     s_tdata,
	// op[2:0]
	input  wire logic [2:0]                         s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// run_state[1:0], motor_enable[2], direction_cw[3], step_pulse[4],
	// step_rate_hz[16:5], pulse_period_us[36:17], steps_taken[68:37],
	// filtered_position[83:69], position_error[98:84], in_position[99]
	output logic      [rppc_pkg::M_TDATA_W-1:0]     m_tdata,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [rppc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rppc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	rppc_pkg::cmd_t cmd;
	rppc_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	rppc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rppc_datapath #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_op     (s_tuser),
		.in_raw    (s_tdata[13:0]),
		.in_tgt    (s_tdata[27:14]),
		.cmd       (cmd),
		.sts       (sts),
		.res_data  (m_tdata)
	);

endmodule
`default_nettype wire
